// File: rtl/advst_pkg.sv
// advst_pkg: shared types, codes and constants for the advertiser rssi table
// used by advst_ctrl, advst_dp and the top level; no dependencies
package advst_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int DIV_STEPS = 40;

	// opcodes
	localparam logic [1:0] OP_OBSERVE  = 2'd0;
	localparam logic [1:0] OP_READ     = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// result status codes
	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_DROPPED = 3'd2;
	localparam logic [2:0] ST_SHOWN   = 3'd3;
	localparam logic [2:0] ST_SKIPPED = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	localparam logic signed [7:0] RSSI_LOW_INIT  = 8'sd127;
	localparam logic signed [7:0] RSSI_HIGH_INIT = -8'sd127;
	localparam logic [31:0] PKT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [47:0]        addr;
		logic [7:0]         atype;
		logic signed [7:0]  latest;
		logic signed [7:0]  lowest;
		logic signed [7:0]  highest;
		logic signed [39:0] sum;
		logic [31:0]        pkts;
		logic [10:0]        plen;
		logic [7:0]         pdu;
		logic [39:0]        last;
	} entry_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_LOOK   = 6'b000100,
		S_UPDATE = 6'b001000,
		S_DIVIDE = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic apply;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic no_div;
		logic div_last;
	} sts_t;

endpackage

// File: rtl/advst_ctrl.sv
// advst_ctrl: sequencer for the advertiser rssi table
// depends on advst_pkg; drives commands into advst_dp
module advst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	output logic               out_valid,
	input  logic               out_stall,
	output advst_pkg::cmd_t    cmd,
	input  advst_pkg::sts_t    sts
);
	advst_pkg::state_t state_q, state_d;
	logic accept;

	assign in_stall  = (state_q != advst_pkg::S_IDLE);
	assign out_valid = (state_q == advst_pkg::S_DONE);
	assign accept    = in_valid & ~in_stall;

	// commands
	always_comb begin
		cmd.load  = accept;
		cmd.scan  = (state_q == advst_pkg::S_SCAN);
		cmd.apply = (state_q == advst_pkg::S_UPDATE) | (state_q == advst_pkg::S_LOOK);
		cmd.step  = (state_q == advst_pkg::S_DIVIDE);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			advst_pkg::S_IDLE: begin
				if (accept) begin
					case (opcode)
						advst_pkg::OP_OBSERVE: state_d = advst_pkg::S_SCAN;
						advst_pkg::OP_READ:    state_d = advst_pkg::S_LOOK;
						advst_pkg::OP_CLEAR:   state_d = advst_pkg::S_DONE;
						default:               state_d = advst_pkg::S_IDLE;
					endcase
				end
			end
			advst_pkg::S_SCAN: begin
				if (sts.scan_done) state_d = advst_pkg::S_UPDATE;
			end
			advst_pkg::S_UPDATE, advst_pkg::S_LOOK: begin
				state_d = sts.no_div ? advst_pkg::S_DONE : advst_pkg::S_DIVIDE;
			end
			advst_pkg::S_DIVIDE: begin
				if (sts.div_last) state_d = advst_pkg::S_DONE;
			end
			advst_pkg::S_DONE: begin
				if (!out_stall) state_d = advst_pkg::S_IDLE;
			end
			default: state_d = advst_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= advst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/advst_dp.sv
// advst_dp: entry memory, valid bits, slot scan, update and mean divider
// depends on advst_pkg; controlled by advst_ctrl
module advst_dp #(
	parameter int TABLE_ENTRIES = advst_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  advst_pkg::cmd_t    cmd,
	output advst_pkg::sts_t    sts,
	input  logic [1:0]         opcode,
	input  logic [47:0]        address,
	input  logic [7:0]         address_type,
	input  logic signed [7:0]  rssi,
	input  logic [10:0]        payload_length,
	input  logic [7:0]         pdu_type,
	input  logic [39:0]        now_ms,
	input  logic [5:0]         entry_index,
	input  logic signed [7:0]  rssi_floor,
	output logic [2:0]         status,
	output logic [5:0]         slot,
	output logic [47:0]        seen_address,
	output logic [7:0]         seen_address_type,
	output logic signed [7:0]  latest_rssi,
	output logic signed [7:0]  lowest_rssi,
	output logic signed [7:0]  highest_rssi,
	output logic signed [7:0]  mean_rssi,
	output logic [31:0]        packet_count,
	output logic [10:0]        last_payload_length,
	output logic [7:0]         last_pdu_type,
	output logic [39:0]        age_ms
);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = IW + 1;
	localparam int KW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] N_C = CW'(TABLE_ENTRIES);
	localparam logic [KW-1:0] N_K = KW'(TABLE_ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	advst_pkg::entry_t mem [TABLE_ENTRIES];
	advst_pkg::entry_t rd_q, old_q, rec_q, base, new_rec, src_rec;
	logic [TABLE_ENTRIES-1:0] valid_q;

	// captured item
	logic [1:0]        op_q;
	logic [47:0]       addr_q;
	logic [7:0]        atype_q;
	logic signed [7:0] rssi_q;
	logic [10:0]       plen_q;
	logic [7:0]        pdu_q;
	logic [39:0]       now_q;
	logic [5:0]        idx_q;
	logic signed [7:0] floor_q;

	// scan state
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] probe_s1, slot_q, free_q;
	logic          probe_v_s1, found_q, free_v_q;
	logic          issue, match, last, full, in_range, show;
	logic          mem_re;
	logic [IW-1:0] rd_idx, tgt, ridx;

	// result and divider
	logic [2:0]  status_q;
	logic [5:0]  slot_out_q;
	logic        zero_q, neg_q;
	logic [39:0] age_q, dvd_q, mq;
	logic [31:0] rem_q;
	logic [32:0] trial;
	logic [5:0]  dcnt_q;
	logic [39:0] sum_abs;
	logic [7:0]  mean_raw;

	assign issue  = cmd.scan & (cnt_q < N_C);
	assign mem_re = issue | cmd.load;
	assign rd_idx = cmd.load ? IW'(entry_index) : cnt_q[IW-1:0];
	assign match  = probe_v_s1 & valid_q[probe_s1] & (rd_q.addr == addr_q)
		& (rd_q.atype == atype_q);
	assign last   = probe_v_s1 & (probe_s1 == LAST_IDX);

	// observe update
	assign full = ~found_q & ~free_v_q;
	assign tgt  = found_q ? slot_q : free_q;
	always_comb begin
		base = old_q;
		if (!found_q) begin
			base.addr    = addr_q;
			base.atype   = atype_q;
			base.latest  = '0;
			base.lowest  = advst_pkg::RSSI_LOW_INIT;
			base.highest = advst_pkg::RSSI_HIGH_INIT;
			base.sum     = '0;
			base.pkts    = '0;
		end
		new_rec = base;
		new_rec.latest  = rssi_q;
		new_rec.lowest  = (rssi_q < base.lowest) ? rssi_q : base.lowest;
		new_rec.highest = (rssi_q > base.highest) ? rssi_q : base.highest;
		if (base.pkts != advst_pkg::PKT_MAX) begin
			new_rec.sum  = base.sum + 40'(rssi_q);
			new_rec.pkts = base.pkts + 32'd1;
		end
		new_rec.plen = plen_q;
		new_rec.pdu  = pdu_q;
		new_rec.last = now_q;
	end

	// read check
	assign ridx     = IW'(idx_q);
	assign in_range = KW'(idx_q) < N_K;
	assign show     = in_range & valid_q[ridx] & (rd_q.latest >= floor_q);
	assign src_rec  = (op_q == advst_pkg::OP_READ) ? rd_q : new_rec;
	assign sum_abs  = src_rec.sum[39] ? 40'(-src_rec.sum) : 40'(src_rec.sum);

	assign sts.scan_done = match | last;
	assign sts.no_div    = (op_q == advst_pkg::OP_READ) ? ~show : full;
	assign sts.div_last  = (dcnt_q == 6'd1);

	// entry memory
	always_ff @(posedge clk) begin
		if (cmd.apply && op_q == advst_pkg::OP_OBSERVE && !full) mem[tgt] <= new_rec;
		if (mem_re) rd_q <= mem[rd_idx];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			probe_v_s1 <= 1'b0;
		end else begin
			if (cmd.load && opcode == advst_pkg::OP_CLEAR) valid_q <= '0;
			if (cmd.apply && op_q == advst_pkg::OP_OBSERVE && !full) valid_q[tgt] <= 1'b1;
			if (cmd.load) probe_v_s1 <= 1'b0;
			else if (cmd.scan) probe_v_s1 <= issue;
		end
	end

	// item capture and scan tracking
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= opcode;
			addr_q   <= address;
			atype_q  <= address_type;
			rssi_q   <= rssi;
			plen_q   <= payload_length;
			pdu_q    <= pdu_type;
			now_q    <= now_ms;
			idx_q    <= entry_index;
			floor_q  <= rssi_floor;
			cnt_q    <= '0;
			found_q  <= 1'b0;
			free_v_q <= 1'b0;
		end
		if (cmd.scan) begin
			probe_s1 <= cnt_q[IW-1:0];
			if (issue) cnt_q <= cnt_q + CW'(1);
			if (match) begin
				found_q <= 1'b1;
				slot_q  <= probe_s1;
				old_q   <= rd_q;
			end
			if (probe_v_s1 && !valid_q[probe_s1] && !free_v_q) begin
				free_v_q <= 1'b1;
				free_q   <= probe_s1;
			end
		end
	end

	// result register and divider
	assign trial = {rem_q, dvd_q[39]};
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q   <= advst_pkg::ST_CLEARED;
			slot_out_q <= '0;
			zero_q     <= 1'b1;
		end
		if (cmd.apply) begin
			rec_q  <= src_rec;
			rem_q  <= '0;
			dvd_q  <= sum_abs;
			neg_q  <= src_rec.sum[39];
			dcnt_q <= 6'(advst_pkg::DIV_STEPS);
			if (op_q == advst_pkg::OP_READ) begin
				status_q   <= show ? advst_pkg::ST_SHOWN : advst_pkg::ST_SKIPPED;
				slot_out_q <= idx_q;
				zero_q     <= ~show;
				age_q      <= (now_q >= rd_q.last) ? (now_q - rd_q.last) : '0;
			end else begin
				status_q   <= full ? advst_pkg::ST_DROPPED
					: (found_q ? advst_pkg::ST_UPDATED : advst_pkg::ST_NEW);
				slot_out_q <= full ? 6'd0 : 6'(tgt);
				zero_q     <= full;
				age_q      <= '0;
			end
		end
		if (cmd.step) begin
			dcnt_q <= dcnt_q - 6'd1;
			if (trial >= {1'b0, rec_q.pkts}) begin
				rem_q <= 32'(trial - {1'b0, rec_q.pkts});
				dvd_q <= {dvd_q[38:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				dvd_q <= {dvd_q[38:0], 1'b0};
			end
		end
	end

	// output fields
	assign mq       = neg_q ? 40'(-dvd_q) : dvd_q;
	assign mean_raw = (rec_q.pkts == '0) ? rec_q.latest : mq[7:0];

	assign status              = status_q;
	assign slot                = slot_out_q;
	assign seen_address        = zero_q ? '0 : rec_q.addr;
	assign seen_address_type   = zero_q ? '0 : rec_q.atype;
	assign latest_rssi         = zero_q ? '0 : rec_q.latest;
	assign lowest_rssi         = zero_q ? '0 : rec_q.lowest;
	assign highest_rssi        = zero_q ? '0 : rec_q.highest;
	assign mean_rssi           = zero_q ? '0 : mean_raw;
	assign packet_count        = zero_q ? '0 : rec_q.pkts;
	assign last_payload_length = zero_q ? '0 : rec_q.plen;
	assign last_pdu_type       = zero_q ? '0 : rec_q.pdu;
	assign age_ms              = zero_q ? '0 : age_q;

endmodule

// File: rtl/advertiser_rssi_statistics_table_unit.sv
// advertiser_rssi_statistics_table_unit: top level of the advertiser rssi table
// depends on advst_pkg, advst_ctrl and advst_dp
//
// channel | signals                  | direction
// input   | in_valid, in_stall, item | in_valid in, in_stall out
// output  | out_valid, out_stall, res| out_valid out, out_stall in
//
// an observe scans the entry memory one slot per cycle until a match or the last
// slot, updates the entry, then runs a 40-step divider for the mean; a drop on a
// full table skips the divider; a read looks up entry_index and runs the same
// divider unless skipped; a clear goes straight to the result; one item is in
// flight, the next is taken once the result has transferred and the unit is idle
// reset clears the valid bits at once; entry payload is undefined until written
// the result holds while out_stall is high and no new item is taken meanwhile
module advertiser_rssi_statistics_table_unit #(
	parameter int TABLE_ENTRIES = advst_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [47:0]        address,
	input  logic [7:0]         address_type,
	input  logic signed [7:0]  rssi,
	input  logic [10:0]        payload_length,
	input  logic [7:0]         pdu_type,
	input  logic [39:0]        now_ms,
	input  logic [5:0]         entry_index,
	input  logic signed [7:0]  rssi_floor,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [5:0]         slot,
	output logic [47:0]        seen_address,
	output logic [7:0]         seen_address_type,
	output logic signed [7:0]  latest_rssi,
	output logic signed [7:0]  lowest_rssi,
	output logic signed [7:0]  highest_rssi,
	output logic signed [7:0]  mean_rssi,
	output logic [31:0]        packet_count,
	output logic [10:0]        last_payload_length,
	output logic [7:0]         last_pdu_type,
	output logic [39:0]        age_ms
);
	advst_pkg::cmd_t cmd;
	advst_pkg::sts_t sts;

	// sequencer
	advst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// table and arithmetic
	advst_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.opcode              (opcode),
		.address             (address),
		.address_type        (address_type),
		.rssi                (rssi),
		.payload_length      (payload_length),
		.pdu_type            (pdu_type),
		.now_ms              (now_ms),
		.entry_index         (entry_index),
		.rssi_floor          (rssi_floor),
		.status              (status),
		.slot                (slot),
		.seen_address        (seen_address),
		.seen_address_type   (seen_address_type),
		.latest_rssi         (latest_rssi),
		.lowest_rssi         (lowest_rssi),
		.highest_rssi        (highest_rssi),
		.mean_rssi           (mean_rssi),
		.packet_count        (packet_count),
		.last_payload_length (last_payload_length),
		.last_pdu_type       (last_pdu_type),
		.age_ms              (age_ms)
	);

`ifndef ASSERT_OFF
	// no new transfer is taken while a result waits
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	// an unknown opcode gives no result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == advst_pkg::OP_RESERVED) |=> !out_valid)
		else $error("result for unknown opcode");

	// a clear answers in the following cycle with the cleared code
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == advst_pkg::OP_CLEAR) |=>
		(out_valid && status == advst_pkg::ST_CLEARED))
		else $error("clear result missing");
`endif

endmodule
